[src/mibs_pkg.sv]
// Shared types, constants and round functions for the MIBS-64 decryption pipeline.
// No dependencies; imported by mibs_stage and mibs64_block_decrypt_core.
`default_nettype none

package mibs_pkg;

  // Configuration port geometry: one 64-bit register at byte address 0
  localparam int ADDR_W = 4;
  localparam int DATA_W = 64;

  // Register index codes, taken from paddr[3]
  localparam logic REG_FINAL_KEY = 1'b0;

  // Forward S-box used by the F function
  localparam logic [3:0] SBOX_FWD [16] = '{
    4'h4, 4'hF, 4'h3, 4'h8, 4'hD, 4'hA, 4'hC, 4'h0,
    4'hB, 4'h5, 4'h7, 4'hE, 4'h2, 4'h6, 4'h1, 4'h9
  };

  // Inverse S-box used by the backward key schedule
  localparam logic [3:0] SBOX_INV [16] = '{
    4'h7, 4'hE, 4'hC, 4'h2, 4'h0, 4'h9, 4'hD, 4'hA,
    4'h3, 4'hF, 4'h5, 4'h8, 4'h6, 4'h4, 4'hB, 4'h1
  };

  // Data carried from one round stage to the next
  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic [63:0] key;
  } mibs_beat_t;

  // Round function: key mix, S-box layer, nibble mix, nibble permutation
  function automatic logic [31:0] mibs_f(input logic [31:0] r, input logic [31:0] k);
    logic [31:0] t;
    logic [31:0] s;
    logic [3:0]  n [8];
    logic [3:0]  y [8];
    t = r ^ k;
    for (int i = 0; i < 8; i++) begin
      s[4*i +: 4] = SBOX_FWD[t[4*i +: 4]];
    end
    // n[0] is the most significant nibble
    for (int i = 0; i < 8; i++) begin
      n[i] = s[(7-i)*4 +: 4];
    end
    y[0] = n[1] ^ n[2] ^ n[3] ^ n[4] ^ n[5] ^ n[6];
    y[1] = n[0] ^ n[2] ^ n[3] ^ n[5] ^ n[6] ^ n[7];
    y[2] = n[0] ^ n[1] ^ n[3] ^ n[4] ^ n[6] ^ n[7];
    y[3] = n[0] ^ n[1] ^ n[2] ^ n[4] ^ n[5] ^ n[7];
    y[4] = n[0] ^ n[1] ^ n[3] ^ n[4] ^ n[5];
    y[5] = n[0] ^ n[1] ^ n[2] ^ n[5] ^ n[6];
    y[6] = n[1] ^ n[2] ^ n[3] ^ n[6] ^ n[7];
    y[7] = n[0] ^ n[2] ^ n[3] ^ n[4] ^ n[7];
    return {y[2], y[0], y[3], y[6], y[7], y[4], y[5], y[1]};
  endfunction

  // Step the key state back by one round
  function automatic logic [63:0] mibs_key_back(input logic [63:0] key, input logic [4:0] rnd);
    logic [63:0] k;
    k = key;
    k[15:11] = k[15:11] ^ rnd;
    k[63:60] = SBOX_INV[k[63:60]];
    return {k[48:0], k[63:49]};
  endfunction

endpackage

`default_nettype wire

[src/mibs_stage.sv]
// One decryption round held in one register stage, with valid/ready flow control.
// Depends on mibs_pkg for the round function, key step and beat type.
`default_nettype none

module mibs_stage
  import mibs_pkg::*;
#(
  parameter int RND = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       up_valid,
  output logic            up_ready,
  input  wire mibs_beat_t up_beat,
  output logic            dn_valid,
  input  wire logic       dn_ready,
  output mibs_beat_t      dn_beat
);

  // Only the low five bits of the round number reach the key
  localparam logic [4:0] RND_BITS = 5'(RND);

  mibs_beat_t beat_next;

  // Compute one Feistel round and step the key back
  always_comb begin
    beat_next.left  = up_beat.right;
    beat_next.right = mibs_f(up_beat.right, up_beat.key[63:32]) ^ up_beat.left;
    beat_next.key   = mibs_key_back(up_beat.key, RND_BITS);
  end

  // Take a new beat whenever this stage is empty or drains downstream
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  // Load payload only on a real beat
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_beat <= beat_next;
    end
  end

endmodule

`default_nettype wire

[src/mibs64_block_decrypt_core.sv]
// MIBS-64 block decryption core: one round per register stage from ciphertext beat to plaintext_valid;
// throughput one block per cycle while plaintext_ready does not stall the output, each stage holds one block.
// Backpressure ripples through per-stage ready, so empty stages are filled even under a stall.
// Synchronous reset empties every stage and clears final_round_key to zero.
// Depends on mibs_pkg and mibs_stage.
`default_nettype none

module mibs64_block_decrypt_core
  import mibs_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  // ciphertext channel
  input  wire logic              ciphertext_valid,
  output logic                   ciphertext_ready,
  input  wire logic [63:0]       ciphertext,
  // plaintext channel
  output logic                   plaintext_valid,
  input  wire logic              plaintext_ready,
  output logic      [63:0]       plaintext
);

  logic [63:0] final_round_key;
  logic        reg_index;
  logic        cfg_write;

  mibs_beat_t  beat  [ROUNDS+1];
  logic        valid [ROUNDS+1];
  logic        ready [ROUNDS+1];
  logic [ROUNDS-1:0] stage_full;

  // Decode the register index from the 8-byte slot
  assign reg_index = paddr[3];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      final_round_key <= '0;
    end else if (cfg_write && (reg_index == REG_FINAL_KEY)) begin
      final_round_key <= pwdata;
    end
  end

  // Read back the register; other slots read as zero
  always_comb begin
    unique case (reg_index)
      REG_FINAL_KEY: prdata = final_round_key;
      default:       prdata = '0;
    endcase
  end

  // Feed the first round: right half is the low word
  assign valid[0]         = ciphertext_valid;
  assign ciphertext_ready = ready[0];
  always_comb begin
    beat[0].left  = ciphertext[63:32];
    beat[0].right = ciphertext[31:0];
    beat[0].key   = final_round_key;
  end

  // Rounds run from ROUNDS down to 1
  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    mibs_stage #(
      .RND (ROUNDS - g)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid[g]),
      .up_ready (ready[g]),
      .up_beat  (beat[g]),
      .dn_valid (valid[g+1]),
      .dn_ready (ready[g+1]),
      .dn_beat  (beat[g+1])
    );
    assign stage_full[g] = valid[g+1];
  end

  // Drive the result from the last stage
  assign ready[ROUNDS]   = plaintext_ready;
  assign plaintext_valid = valid[ROUNDS];
  assign plaintext       = {beat[ROUNDS].left, beat[ROUNDS].right};

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !plaintext_valid)
    else $error("result valid right after reset");

  // An empty output stage never blocks the input
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !plaintext_valid |-> ciphertext_ready)
    else $error("input stalled with output stage empty");

  // A full pipeline under output stall must refuse input
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    ((&stage_full) && !plaintext_ready) |-> !ciphertext_ready)
    else $error("input accepted into a full stalled pipeline");

  // A stalled result stays in the last stage
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (plaintext_valid && !plaintext_ready) |=> (plaintext_valid && $stable(plaintext)))
    else $error("stalled result dropped or changed");

endmodule

`default_nettype wire
